// File: sv/dthr_pkg.sv
// Shared types and constants for the depth tap/hold resolver.
`timescale 1ns / 1ps

package dthr_pkg;

    localparam int TIME_BITS     = 32;
    localparam int THR_BITS      = 16;
    localparam int OP_BITS       = 2;
    localparam int DEC_BITS      = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [OP_BITS-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;

    localparam logic [DEC_BITS-1:0] D_PENDING = 2'd0;
    localparam logic [DEC_BITS-1:0] D_TAP     = 2'd1;
    localparam logic [DEC_BITS-1:0] D_HOLD    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REST_LEVEL      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_THRESHOLD  = 2'd2;

    localparam logic [THR_BITS-1:0] TIME_THRESHOLD_RESET = 16'd200;

    typedef struct packed {
        logic               fire;
        logic [OP_BITS-1:0] op;
    } t_step;

endpackage

// File: sv/dthr_in_if.sv
// Valid/ready channel interfaces for input events and decisions.
`timescale 1ns / 1ps

interface dthr_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                                valid;
    logic                                ready;
    logic [dthr_pkg::OP_BITS-1:0]        op;
    logic [SAMPLE_BITS-1:0]              sample;
    logic [dthr_pkg::TIME_BITS-1:0]      timestamp;

    modport source (output valid, output op, output sample, output timestamp, input ready);
    modport sink   (input valid, input op, input sample, input timestamp, output ready);
endinterface

interface dthr_out_if;
    logic                              valid;
    logic                              ready;
    logic [dthr_pkg::DEC_BITS-1:0]     decision;

    modport source (output valid, output decision, input ready);
    modport sink   (input valid, input decision, output ready);
endinterface

// File: sv/depth_tap_hold_resolver.sv
// Top level of the depth tap/hold resolver: input and result registers.
// An accepted event is held in the input register; its decision is captured in the result
// register when the step fires and is offered from there.
// Throughput: one event per cycle while the receiver takes results; the state update
// and decision are one compare-and-update step between the input and result registers.
// Reset (synchronous, active low) empties both registers, sets the decision to
// pending, releases the key and restores the configuration defaults.
`timescale 1ns / 1ps

module depth_tap_hold_resolver #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dthr_in_if.sink                              i_in,
    dthr_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [dthr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [dthr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    logic                              r_in_valid;
    logic [dthr_pkg::OP_BITS-1:0]      r_in_op;
    logic [SAMPLE_BITS-1:0]            r_in_sample;
    logic [dthr_pkg::TIME_BITS-1:0]    r_in_timestamp;
    logic                              r_out_valid;
    logic [dthr_pkg::DEC_BITS-1:0]     r_out_decision;

    logic                              advance;
    logic                              in_take;
    dthr_pkg::t_step                   step;
    logic [SAMPLE_BITS-1:0]            rest_level;
    logic [SAMPLE_BITS-1:0]            depth_threshold;
    logic [dthr_pkg::THR_BITS-1:0]     time_threshold;
    logic [dthr_pkg::DEC_BITS-1:0]     decision;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;
    assign step.fire  = r_in_valid && advance;
    assign step.op    = r_in_op;

    dthr_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_rest_level      (rest_level),
        .o_depth_threshold (depth_threshold),
        .o_time_threshold  (time_threshold)
    );

    dthr_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_sample          (r_in_sample),
        .i_timestamp       (r_in_timestamp),
        .i_rest_level      (rest_level),
        .i_depth_threshold (depth_threshold),
        .i_time_threshold  (time_threshold),
        .o_decision        (decision)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op        <= i_in.op;
            r_in_sample    <= i_in.sample;
            r_in_timestamp <= i_in.timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.fire) begin
            r_out_decision <= decision;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.decision = r_out_decision;

    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.fire |=> r_out_valid)
        else $error("processed event produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_decision))
        else $error("stalled result was overwritten");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance
        |=> r_in_valid && $stable(r_in_op) && $stable(r_in_timestamp))
        else $error("waiting input was overwritten");
endmodule

// File: sv/dthr_cfg.sv
// Configuration register file: rest level and the two thresholds.
`timescale 1ns / 1ps

module dthr_cfg #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dthr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [dthr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic [SAMPLE_BITS-1:0]               o_rest_level,
    output logic [SAMPLE_BITS-1:0]               o_depth_threshold,
    output logic [dthr_pkg::THR_BITS-1:0]        o_time_threshold
);
    logic [SAMPLE_BITS-1:0]          r_rest_level;
    logic [SAMPLE_BITS-1:0]          r_depth_threshold;
    logic [dthr_pkg::THR_BITS-1:0]   r_time_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_level      <= '0;
            r_depth_threshold <= '1;
            r_time_threshold  <= dthr_pkg::TIME_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dthr_pkg::CFG_REST_LEVEL: begin
                    r_rest_level <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                dthr_pkg::CFG_DEPTH_THRESHOLD: begin
                    r_depth_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                dthr_pkg::CFG_TIME_THRESHOLD: begin
                    r_time_threshold <= i_cfg_data[dthr_pkg::THR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rest_level      = r_rest_level;
    assign o_depth_threshold = r_depth_threshold;
    assign o_time_threshold  = r_time_threshold;
endmodule

// File: sv/dthr_core.sv
// Key state and the tap/hold decision logic applied to one event.
`timescale 1ns / 1ps

module dthr_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dthr_pkg::t_step                   i_step,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    input  logic [dthr_pkg::TIME_BITS-1:0]    i_timestamp,
    input  logic [SAMPLE_BITS-1:0]            i_rest_level,
    input  logic [SAMPLE_BITS-1:0]            i_depth_threshold,
    input  logic [dthr_pkg::THR_BITS-1:0]     i_time_threshold,
    output logic [dthr_pkg::DEC_BITS-1:0]     o_decision
);
    logic [dthr_pkg::DEC_BITS-1:0]   r_verdict;
    logic [dthr_pkg::TIME_BITS-1:0]  r_press_time;
    logic [SAMPLE_BITS-1:0]          r_peak;
    logic                            r_held;

    logic [dthr_pkg::DEC_BITS-1:0]   n_verdict;
    logic [dthr_pkg::TIME_BITS-1:0]  n_press_time;
    logic [SAMPLE_BITS-1:0]          n_peak;
    logic                            n_held;

    logic [SAMPLE_BITS-1:0]          depth;
    logic [SAMPLE_BITS-1:0]          peak_upd;
    logic [dthr_pkg::TIME_BITS-1:0]  elapsed;

    always_comb begin
        depth    = (i_sample > i_rest_level) ? (i_sample - i_rest_level) : '0;
        peak_upd = (depth > r_peak) ? depth : r_peak;
        elapsed  = i_timestamp - r_press_time;

        n_verdict    = r_verdict;
        n_press_time = r_press_time;
        n_peak       = r_peak;
        n_held       = r_held;
        if (i_step.fire) begin
            case (i_step.op)
                dthr_pkg::OP_PRESS: begin
                    n_verdict    = dthr_pkg::D_PENDING;
                    n_press_time = i_timestamp;
                    n_peak       = '0;
                    n_held       = 1'b1;
                end
                dthr_pkg::OP_UPDATE: begin
                    if (r_verdict == dthr_pkg::D_PENDING && r_held) begin
                        n_peak = peak_upd;
                        if (peak_upd >= i_depth_threshold ||
                            elapsed >= {{(dthr_pkg::TIME_BITS-dthr_pkg::THR_BITS){1'b0}},
                                        i_time_threshold}) begin
                            n_verdict = dthr_pkg::D_HOLD;
                        end
                    end
                end
                dthr_pkg::OP_RELEASE: begin
                    n_held = 1'b0;
                    if (r_verdict == dthr_pkg::D_PENDING) begin
                        n_verdict = dthr_pkg::D_TAP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict    <= dthr_pkg::D_PENDING;
            r_press_time <= '0;
            r_peak       <= '0;
            r_held       <= 1'b0;
        end else begin
            r_verdict    <= n_verdict;
            r_press_time <= n_press_time;
            r_peak       <= n_peak;
            r_held       <= n_held;
        end
    end

    assign o_decision = n_verdict;

    a_press_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.fire && i_step.op == dthr_pkg::OP_PRESS
        |=> r_verdict == dthr_pkg::D_PENDING && r_held && r_peak == '0)
        else $error("press did not arm the key");

    a_release_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.fire && i_step.op == dthr_pkg::OP_RELEASE
        |=> !r_held && r_verdict != dthr_pkg::D_PENDING)
        else $error("release left the key pending or pressed");

    a_update_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.fire && i_step.op == dthr_pkg::OP_UPDATE &&
        (r_verdict != dthr_pkg::D_PENDING || !r_held)
        |=> $stable(r_verdict) && $stable(r_peak))
        else $error("update changed a latched or released key");
endmodule

// File: verif/dthr_decision_check.sv
// Watches both channels of the resolver, predicts every decision and compares it.
`timescale 1ns / 1ps

module dthr_decision_check #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dthr_in_if                                 i_in_mon,
    dthr_out_if                                i_out_mon,
    input  logic                               i_cfg_we,
    input  logic [dthr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [dthr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);

    logic [SAMPLE_BITS-1:0]          rest_lvl;
    logic [SAMPLE_BITS-1:0]          depth_thr;
    logic [dthr_pkg::THR_BITS-1:0]   time_thr;

    logic [dthr_pkg::DEC_BITS-1:0]   key_decision;
    logic [dthr_pkg::TIME_BITS-1:0]  pressed_at;
    logic [SAMPLE_BITS-1:0]          deepest;
    logic                            key_down;

    logic [dthr_pkg::DEC_BITS-1:0]   decision_q [$];
    logic [dthr_pkg::DEC_BITS-1:0]   wanted;
    int                              mismatches;

    function automatic logic [dthr_pkg::DEC_BITS-1:0] resolve_event(
        input logic [dthr_pkg::OP_BITS-1:0]   op,
        input logic [SAMPLE_BITS-1:0]         sample,
        input logic [dthr_pkg::TIME_BITS-1:0] ts
    );
        logic [SAMPLE_BITS-1:0]         depth;
        logic [dthr_pkg::TIME_BITS-1:0] elapsed;
        case (op)
            dthr_pkg::OP_PRESS: begin
                key_decision = dthr_pkg::D_PENDING;
                pressed_at   = ts;
                deepest      = '0;
                key_down     = 1'b1;
            end
            dthr_pkg::OP_UPDATE: begin
                if (key_decision == dthr_pkg::D_PENDING && key_down) begin
                    depth = (sample > rest_lvl) ? sample - rest_lvl : '0;
                    if (depth > deepest) begin
                        deepest = depth;
                    end
                    elapsed = ts - pressed_at;
                    if (deepest >= depth_thr ||
                        elapsed >= {{(dthr_pkg::TIME_BITS-dthr_pkg::THR_BITS){1'b0}},
                                    time_thr}) begin
                        key_decision = dthr_pkg::D_HOLD;
                    end
                end
            end
            dthr_pkg::OP_RELEASE: begin
                key_down = 1'b0;
                if (key_decision == dthr_pkg::D_PENDING) begin
                    key_decision = dthr_pkg::D_TAP;
                end
            end
            default: begin
            end
        endcase
        return key_decision;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rest_lvl      = '0;
            depth_thr     = '1;
            time_thr      = dthr_pkg::TIME_THRESHOLD_RESET;
            key_decision  = dthr_pkg::D_PENDING;
            pressed_at    = '0;
            deepest       = '0;
            key_down      = 1'b0;
            mismatches    = 0;
            decision_q.delete();
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dthr_pkg::CFG_REST_LEVEL: begin
                        rest_lvl = i_cfg_data[SAMPLE_BITS-1:0];
                    end
                    dthr_pkg::CFG_DEPTH_THRESHOLD: begin
                        depth_thr = i_cfg_data[SAMPLE_BITS-1:0];
                    end
                    dthr_pkg::CFG_TIME_THRESHOLD: begin
                        time_thr = i_cfg_data[dthr_pkg::THR_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (decision_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected decision transfer: got %0d", i_out_mon.decision);
                    end
                    mismatches++;
                end else begin
                    wanted = decision_q.pop_front();
                    if (i_out_mon.decision !== wanted) begin
                        if (mismatches < 10) begin
                            $display("decision mismatch: expected %0d, got %0d",
                                     wanted, i_out_mon.decision);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decision_q.push_back(resolve_event(i_in_mon.op, i_in_mon.sample,
                                                   i_in_mon.timestamp));
            end
            o_fail_count  <= mismatches;
            o_outstanding <= decision_q.size();
        end
    end

endmodule

// File: verif/tb_depth_tap_hold_resolver.sv
// Testbench top for the depth tap/hold resolver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_depth_tap_hold_resolver;

    localparam int SAMPLE_BITS  = 12;
    localparam int OP_W         = dthr_pkg::OP_BITS;
    localparam int CFG_W        = dthr_pkg::CFG_DATA_BITS;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASES       = 6;
    localparam int LONG_STALL   = 400;
    localparam int CYCLE_LIMIT  = 250000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                cfg_we;
    logic [dthr_pkg::CFG_IDX_BITS-1:0]   cfg_idx;
    logic [CFG_W-1:0]                    cfg_data;
    int                                  fail_count;
    int                                  outstanding;

    int sent;
    bit no_idle;
    int cfg_rest;
    int cfg_depth;
    int cfg_time;

    dthr_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    dthr_out_if                             out_ch ();

    depth_tap_hold_resolver #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dthr_decision_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_decision_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_event(input logic [OP_W-1:0] op,
                              input logic [SAMPLE_BITS-1:0] smp,
                              input logic [dthr_pkg::TIME_BITS-1:0] ts);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.sample    <= smp;
        in_ch.timestamp <= ts;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [dthr_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_W-1:0] data);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_thresholds(input int rest, input int depth, input int hold_ms);
        cfg_rest  = rest;
        cfg_depth = depth;
        cfg_time  = hold_ms;
        write_reg(dthr_pkg::CFG_REST_LEVEL, CFG_W'(rest));
        write_reg(dthr_pkg::CFG_DEPTH_THRESHOLD, CFG_W'(depth));
        write_reg(dthr_pkg::CFG_TIME_THRESHOLD, CFG_W'(hold_ms));
    endtask

    task automatic play_keystroke();
        logic [dthr_pkg::TIME_BITS-1:0] now;
        int                             steps;
        int                             smp;
        now = $urandom;
        send_event(dthr_pkg::OP_PRESS, SAMPLE_BITS'($urandom), now);
        steps = $urandom_range(0, 7);
        repeat (steps) begin
            now += $urandom_range(0, cfg_time / 3 + 2);
            if ($urandom_range(0, 3) == 0) begin
                smp = $urandom_range(0, 4095);
            end else begin
                smp = cfg_rest + $urandom_range(0, cfg_depth + cfg_depth / 4 + 4);
            end
            if (smp > 4095) begin
                smp = 4095;
            end
            send_event(dthr_pkg::OP_UPDATE, smp[SAMPLE_BITS-1:0], now);
        end
        if ($urandom_range(0, 4) != 0) begin
            send_event(dthr_pkg::OP_RELEASE, SAMPLE_BITS'($urandom),
                       now + $urandom_range(0, 50));
        end
    endtask

    task automatic send_noise();
        logic [OP_W-1:0] op;
        op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
        send_event(op, SAMPLE_BITS'($urandom), $urandom);
    endtask

    // Receiver: random hold-offs per transfer, two long stalls and one stretch at full rate.
    initial begin
        int gap;
        int taken;
        out_ch.ready <= 1'b0;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken == 150 || taken == 1100) begin
                gap = LONG_STALL;
            end else if (taken >= 500 && taken < 800) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 5);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    initial begin
        int target;
        sent      = 0;
        no_idle   = 1'b0;
        cfg_rest  = 0;
        cfg_depth = 4095;
        cfg_time  = 200;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= dthr_pkg::CFG_REST_LEVEL;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= dthr_pkg::OP_PRESS;
        in_ch.sample    <= '0;
        in_ch.timestamp <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_event(dthr_pkg::OP_RELEASE, 12'h000, 32'd0);
        send_event(dthr_pkg::OP_UPDATE,  12'hFFF, 32'd0);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'd100);
        send_event(dthr_pkg::OP_UPDATE,  12'h000, 32'd100);
        send_event(dthr_pkg::OP_UPDATE,  12'hFFF, 32'd150);
        send_event(dthr_pkg::OP_UPDATE,  12'h000, 32'd151);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'hFFFF_FF00);
        send_event(dthr_pkg::OP_UPDATE,  12'h00A, 32'h0000_0010);
        send_event(dthr_pkg::OP_RELEASE, 12'h000, 32'h0000_0011);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'd5);
        send_event(dthr_pkg::OP_RELEASE, 12'h000, 32'd6);
        send_event(dthr_pkg::OP_UPDATE,  12'hFFF, 32'd7);
        send_event(OP_UNUSED,            12'hFFF, 32'hFFFF_FFFF);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'hFFFF_FFFF);
        send_event(dthr_pkg::OP_UPDATE,  12'h800, 32'hFFFF_FFFF);
        send_event(OP_UNUSED,            12'hFFF, 32'd0);
        send_event(dthr_pkg::OP_UPDATE,  12'h000, 32'h0000_00C7);

        set_thresholds(4095, 0, 0);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'h0000_1234);
        send_event(dthr_pkg::OP_UPDATE,  12'h000, 32'h0000_1234);

        set_thresholds(2048, 100, 65535);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'h8000_0000);
        send_event(dthr_pkg::OP_UPDATE,  12'd2000, 32'h8000_0001);
        send_event(dthr_pkg::OP_UPDATE,  12'd2100, 32'h8000_0002);
        send_event(dthr_pkg::OP_UPDATE,  12'd2148, 32'h8000_0003);
        send_event(dthr_pkg::OP_PRESS,   12'h000, 32'd0);
        send_event(dthr_pkg::OP_UPDATE,  12'h000, 32'd65534);
        send_event(dthr_pkg::OP_UPDATE,  12'h000, 32'd65535);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_thresholds(0, 4095, 65535);
                1: set_thresholds(4095, 0, 0);
                2: set_thresholds($urandom_range(0, 1500), $urandom_range(1, 2000),
                                  $urandom_range(0, 1000));
                3: set_thresholds($urandom_range(0, 300), $urandom_range(1, 400),
                                  $urandom_range(0, 60));
                4: set_thresholds($urandom_range(0, 2500), $urandom_range(1, 1500),
                                  $urandom_range(100, 400));
                default: set_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095),
                                        $urandom_range(0, 65535));
            endcase
            no_idle = (phase == 3);
            target  = sent + PHASE_ITEMS;
            while (sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    play_keystroke();
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
